// ===== hdl/stsc_pkg.sv =====
// shared types, constants and character helpers of the script token scanner
package stsc_pkg;

  localparam int KwBufLen     = 8;
  localparam int PosWidth     = 16;
  localparam int MantWidth    = 32;
  localparam int KindWidth    = 5;
  localparam int FracWidth    = 8;
  localparam int WordLenWidth = $clog2(KwBufLen + 2);
  localparam int LetterIdxW   = $clog2(KwBufLen);
  localparam int NumKw        = 9;

  localparam logic [MantWidth-1:0] MantMax = {MantWidth{1'b1}};
  localparam logic [FracWidth-1:0] FracMax = {FracWidth{1'b1}};
  localparam logic [PosWidth-1:0]  PosMax  = {PosWidth{1'b1}};

  // token kind codes
  localparam logic [KindWidth-1:0] TkEof       = 5'd0;
  localparam logic [KindWidth-1:0] TkNumber    = 5'd1;
  localparam logic [KindWidth-1:0] TkIdent     = 5'd2;
  localparam logic [KindWidth-1:0] TkKwBase    = 5'd3;
  localparam logic [KindWidth-1:0] TkSemi      = 5'd12;
  localparam logic [KindWidth-1:0] TkLParen    = 5'd13;
  localparam logic [KindWidth-1:0] TkRParen    = 5'd14;
  localparam logic [KindWidth-1:0] TkLBrace    = 5'd15;
  localparam logic [KindWidth-1:0] TkRBrace    = 5'd16;
  localparam logic [KindWidth-1:0] TkPlus      = 5'd17;
  localparam logic [KindWidth-1:0] TkMinus     = 5'd18;
  localparam logic [KindWidth-1:0] TkStar      = 5'd19;
  localparam logic [KindWidth-1:0] TkSlash     = 5'd20;
  localparam logic [KindWidth-1:0] TkLess      = 5'd21;
  localparam logic [KindWidth-1:0] TkEqual     = 5'd22;
  localparam logic [KindWidth-1:0] TkComma     = 5'd23;
  localparam logic [KindWidth-1:0] TkError     = 5'd24;

  // keyword text, right-justified: character i sits at byte (len - 1 - i)
  localparam logic [63:0] KwText [NumKw] = '{
    64'("print"), 64'("while"), 64'("do"), 64'("end"), 64'("function"),
    64'("if"), 64'("then"), 64'("else"), 64'("return")
  };
  localparam int KwLen [NumKw] = '{5, 5, 2, 3, 8, 2, 4, 4, 6};

  typedef enum logic [3:0] {
    ModeIdle = 4'b0001,
    ModeInt  = 4'b0010,
    ModeFrac = 4'b0100,
    ModeWord = 4'b1000
  } scan_mode_e;

  typedef logic [KwBufLen-1:0][7:0] letters_t;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [MantWidth-1:0] mantissa;
    logic [FracWidth-1:0] frac;
    logic                 ovf;
    logic [PosWidth-1:0]  start;
    logic [PosWidth-1:0]  length;
    logic                 last;
  } token_t;

  typedef struct packed {
    token_t      first;
    token_t      second;
    logic [1:0]  count;
  } lex_out_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  // punctuation kind, or TkEof when the byte is no mark
  function automatic logic [KindWidth-1:0] punct_kind(logic [7:0] c);
    logic [KindWidth-1:0] kind;
    case (c)
      8'(";"):  kind = TkSemi;
      8'("("):  kind = TkLParen;
      8'(")"):  kind = TkRParen;
      8'("{"):  kind = TkLBrace;
      8'("}"):  kind = TkRBrace;
      8'("+"):  kind = TkPlus;
      8'("-"):  kind = TkMinus;
      8'("*"):  kind = TkStar;
      8'("/"):  kind = TkSlash;
      8'("<"):  kind = TkLess;
      8'("="):  kind = TkEqual;
      8'(","):  kind = TkComma;
      default: kind = TkEof;
    endcase
    return kind;
  endfunction

  // nine parallel compares of the word buffer against the keyword list
  function automatic logic [KindWidth-1:0] keyword_kind(letters_t l,
                                                        logic [WordLenWidth-1:0] len);
    logic [KindWidth-1:0] kind;
    logic                 hit;
    kind = TkIdent;
    for (int k = NumKw - 1; k >= 0; k--) begin
      hit = (len == WordLenWidth'(KwLen[k]));
      for (int i = 0; i < KwBufLen; i++) begin
        if (i < KwLen[k] && l[i] != KwText[k][8*((KwLen[k] - 1 - i) & 7) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = TkKwBase + KindWidth'(k);
      end
    end
    return kind;
  endfunction

endpackage

// ===== hdl/stsc_lexer.sv =====
// scanner state and per-word token decision, up to two tokens per word
module stsc_lexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              kind_i,
  input  logic [7:0]        char_i,
  output stsc_pkg::lex_out_t lex_o
);
  import stsc_pkg::*;

  scan_mode_e              mode_q, mode_d;
  letters_t                letters_q;
  logic [WordLenWidth-1:0] len_q, len_d;
  logic [MantWidth-1:0]    mant_q, mant_d;
  logic [FracWidth-1:0]    frac_q, frac_d;
  logic                    sat_q, sat_d;
  logic [PosWidth-1:0]     start_q, start_d;
  logic [PosWidth-1:0]     pos_q, pos_d;
  logic                    err_q, err_d;

  logic                    let_we;
  logic [LetterIdxW-1:0]   let_idx;
  logic [7:0]              let_data;

  logic [3:0]              digit;
  logic [MantWidth+3:0]    mant_acc;
  logic                    mant_over;
  logic                    is_num, has_pend;
  token_t                  tok_pend, tok_new, tok_err;
  logic [KindWidth-1:0]    pkind;
  logic                    closed, consumed, has_new;
  logic [PosWidth-1:0]     pos_inc;

  // times ten plus digit as shift-add
  assign digit     = 4'(char_i - 8'h30);
  assign mant_acc  = (MantWidth+4)'({mant_q, 3'b000}) + (MantWidth+4)'({mant_q, 1'b0})
                   + (MantWidth+4)'(digit);
  assign mant_over = sat_q || (mant_acc > (MantWidth+4)'(MantMax));

  assign is_num   = (mode_q == ModeInt) || (mode_q == ModeFrac);
  assign has_pend = (mode_q != ModeIdle);
  assign pkind    = punct_kind(char_i);
  assign pos_inc  = (pos_q != PosMax) ? pos_q + 1'b1 : pos_q;

  always_comb begin
    tok_pend          = '0;
    tok_pend.kind     = is_num ? TkNumber : keyword_kind(letters_q, len_q);
    tok_pend.mantissa = is_num ? mant_q : '0;
    tok_pend.frac     = is_num ? frac_q : '0;
    tok_pend.ovf      = is_num ? sat_q : 1'b0;
    tok_pend.start    = start_q;
    tok_pend.length   = pos_q - start_q;
    tok_err           = '0;
    tok_err.kind      = TkError;
    tok_err.start     = start_q;
    tok_err.length    = PosWidth'(1);
  end

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    mant_d   = mant_q;
    frac_d   = frac_q;
    sat_d    = sat_q;
    start_d  = start_q;
    pos_d    = pos_q;
    err_d    = err_q;
    let_we   = 1'b0;
    let_idx  = len_q[LetterIdxW-1:0];
    let_data = char_i;
    lex_o    = '0;
    tok_new  = '0;
    closed   = 1'b0;
    consumed = 1'b0;
    has_new  = 1'b0;

    if (step_i) begin
      if (err_q) begin
        lex_o.first = tok_err;
        lex_o.count = 2'd1;
      end else if (kind_i) begin
        // end of source: flush pending token, then eof
        tok_new.kind  = TkEof;
        tok_new.start = pos_q;
        mode_d        = ModeIdle;
        if (has_pend) begin
          lex_o.first  = tok_pend;
          lex_o.second = tok_new;
          lex_o.count  = 2'd2;
        end else begin
          lex_o.first = tok_new;
          lex_o.count = 2'd1;
        end
      end else begin
        pos_d = pos_inc;
        case (mode_q)
          ModeInt, ModeFrac: begin
            if (is_digit(char_i)) begin
              consumed = 1'b1;
              sat_d    = mant_over;
              mant_d   = mant_over ? MantMax : mant_acc[MantWidth-1:0];
              if (mode_q == ModeFrac && frac_q != FracMax) begin
                frac_d = frac_q + 1'b1;
              end
            end else if (char_i == 8'(".") && mode_q == ModeInt) begin
              consumed = 1'b1;
              mode_d   = ModeFrac;
            end else begin
              closed = 1'b1;
            end
          end
          ModeWord: begin
            if (is_alpha(char_i) || is_digit(char_i)) begin
              consumed = 1'b1;
              let_we   = (len_q < WordLenWidth'(KwBufLen));
              if (len_q <= WordLenWidth'(KwBufLen)) begin
                len_d = len_q + 1'b1;
              end
            end else begin
              closed = 1'b1;
            end
          end
          default: ;
        endcase

        if (!consumed) begin
          if (closed) begin
            mode_d = ModeIdle;
          end
          if (is_space(char_i)) begin
            // skipped
          end else if (is_digit(char_i)) begin
            mode_d  = ModeInt;
            start_d = pos_q;
            mant_d  = MantWidth'(digit);
            sat_d   = 1'b0;
            frac_d  = '0;
          end else if (is_alpha(char_i)) begin
            mode_d  = ModeWord;
            start_d = pos_q;
            let_we  = 1'b1;
            let_idx = '0;
            len_d   = WordLenWidth'(1);
          end else if (pkind != TkEof) begin
            has_new        = 1'b1;
            tok_new.kind   = pkind;
            tok_new.start  = pos_q;
            tok_new.length = PosWidth'(1);
          end else begin
            // bad byte, sticky
            has_new        = 1'b1;
            err_d          = 1'b1;
            start_d        = pos_q;
            tok_new.kind   = TkError;
            tok_new.start  = pos_q;
            tok_new.length = PosWidth'(1);
          end

          if (closed) begin
            lex_o.first = tok_pend;
            if (has_new) begin
              lex_o.second = tok_new;
              lex_o.count  = 2'd2;
            end else begin
              lex_o.count = 2'd1;
            end
          end else if (has_new) begin
            lex_o.first = tok_new;
            lex_o.count = 2'd1;
          end
        end
      end
    end

    if (lex_o.count == 2'd1) begin
      lex_o.first.last = 1'b1;
    end
    if (lex_o.count == 2'd2) begin
      lex_o.second.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      len_q   <= '0;
      mant_q  <= '0;
      frac_q  <= '0;
      sat_q   <= 1'b0;
      start_q <= '0;
      pos_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      mant_q  <= mant_d;
      frac_q  <= frac_d;
      sat_q   <= sat_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
    end
  end

  // word buffer, no reset: only entries below the word length are compared
  always_ff @(posedge clk_i) begin
    if (let_we) begin
      letters_q[let_idx] <= let_data;
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && err_q |-> lex_o.count == 2'd1 && lex_o.first.kind == TkError)
    else $error("error state gave something other than one error token");

  a_word_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= WordLenWidth'(KwBufLen + 1))
    else $error("word length ran past its cap");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !err_q && kind_i |->
      (lex_o.count == 2'd1 && lex_o.first.kind == TkEof) ||
      (lex_o.count == 2'd2 && lex_o.second.kind == TkEof))
    else $error("end of source did not close with an eof token");
`endif

endmodule

// ===== hdl/script_token_scanner.sv =====
// top level of the script token scanner: input register, lexer, token queue
//
// Streaming lexer. Each input word is one source byte (kind 0) or an end-of-source
// mark (kind 1). Words are taken into an input register, decided by the lexer
// against the scan state, and the zero, one or two tokens each word
// gives go into a four-entry token queue that drives the output port. A new word
// is accepted every cycle as long as the queue has room for two tokens, so the
// input runs at one word per cycle; the output gives one token per cycle while the
// receiver is ready, so a word that ends a pending token and adds a mark of its own
// gives the output two tokens to send. The first token of a word goes through the
// input register and into the token queue before it is valid at the output. The final
// token caused by a word carries last_of_run. A bad byte gives an error token and
// every later word repeats it until reset.
module script_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_kind_i,
  input  logic [7:0]  in_character_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [stsc_pkg::KindWidth-1:0] out_token_kind_o,
  output logic [stsc_pkg::MantWidth-1:0] out_mantissa_o,
  output logic [stsc_pkg::FracWidth-1:0] out_fraction_digits_o,
  output logic        out_mantissa_overflow_o,
  output logic [stsc_pkg::PosWidth-1:0]  out_start_offset_o,
  output logic [stsc_pkg::PosWidth-1:0]  out_token_length_o,
  output logic        out_last_of_run_o
);
  import stsc_pkg::*;

  localparam int FifoDepth = 4;
  localparam int PtrWidth  = $clog2(FifoDepth);
  localparam int CntWidth  = $clog2(FifoDepth + 1);

  // input register
  logic        in_valid_q;
  logic        in_kind_q;
  logic [7:0]  in_char_q;
  logic        in_fire;
  logic        step;

  // token queue
  token_t                fifo_q [FifoDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  pop;
  lex_out_t              lex;
  token_t                head;

  // a word is processed only when the queue can take both of its tokens
  assign step       = in_valid_q && (cnt_q <= CntWidth'(FifoDepth - 2));
  assign in_ready_o = !in_valid_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_kind_q <= in_kind_i;
      in_char_q <= in_character_i;
    end
  end

  stsc_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .kind_i (in_kind_q),
    .char_i (in_char_q),
    .lex_o  (lex)
  );

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign head        = fifo_q[rd_ptr_q];

  // push up to two tokens per cycle, pop at most one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrWidth'(lex.count);
      rd_ptr_q <= rd_ptr_q + PtrWidth'(pop);
      cnt_q    <= cnt_q + CntWidth'(lex.count) - CntWidth'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (lex.count != 2'd0) begin
      fifo_q[wr_ptr_q] <= lex.first;
    end
    if (lex.count == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= lex.second;
    end
  end

  assign out_token_kind_o        = head.kind;
  assign out_mantissa_o          = head.mantissa;
  assign out_fraction_digits_o   = head.frac;
  assign out_mantissa_overflow_o = head.ovf;
  assign out_start_offset_o      = head.start;
  assign out_token_length_o      = head.length;
  assign out_last_of_run_o       = head.last;

`ifndef SYNTHESIS
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntWidth + 1)'(cnt_q) + (CntWidth + 1)'(lex.count) <= (CntWidth + 1)'(FifoDepth))
    else $error("token queue overflow");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(head))
    else $error("output word changed while waiting");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && (cnt_q > CntWidth'(FifoDepth - 2)) |-> !in_ready_o)
    else $error("input taken while the queue lacked room");
`endif

endmodule

// ===== verif/tb.sv =====
// testbench of the script token scanner: random byte streams checked against a scan predictor
module tb;
  import stsc_pkg::*;

  // predicts the tokens of each accepted word and checks the tokens that come out
  class token_scoreboard;
    token_t          expected_q[$];
    token_t          run_q[$];
    int              mismatches;
    string           kw_words[NumKw];
    string           mark_chars;
    // scanner state as predicted
    scan_mode_e      mode;
    logic [7:0]      letters[KwBufLen];
    int              word_len;
    longint unsigned mant;
    int              frac_cnt;
    bit              mant_sat;
    int              tok_start;
    int              pos;
    bit              stuck;

    function new();
      kw_words   = '{"print", "while", "do", "end", "function", "if", "then", "else",
                     "return"};
      mark_chars = ";(){}+-*/<=,";
      mode       = ModeIdle;
      word_len   = 0;
      mant       = 0;
      frac_cnt   = 0;
      mant_sat   = 1'b0;
      tok_start  = 0;
      pos        = 0;
      stuck      = 1'b0;
      mismatches = 0;
      foreach (letters[i]) letters[i] = 8'h00;
    endfunction

    function bit digit_byte(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function bit letter_byte(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function bit blank_byte(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    // position of the byte in the mark list, -1 if it is no mark
    function int mark_slot(logic [7:0] c);
      for (int k = 0; k < 12; k++) begin
        if (mark_chars[k] == c) return k;
      end
      return -1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_token(logic [KindWidth-1:0] kind, longint unsigned m, int f, bit o,
                             int s, int l);
      token_t t;
      t.kind     = kind;
      t.mantissa = MantWidth'(m);
      t.frac     = FracWidth'(f);
      t.ovf      = o;
      t.start    = PosWidth'(s);
      t.length   = PosWidth'(l);
      t.last     = 1'b0;
      run_q.push_back(t);
    endfunction

    function void add_digit(int d);
      longint unsigned top;
      top = MantMax;
      if (mant_sat || mant > (top - d) / 10) begin
        mant     = top;
        mant_sat = 1'b1;
      end else begin
        mant = mant * 10 + d;
      end
    endfunction

    // emit the number or word in progress, if any
    function void finish_pending();
      logic [KindWidth-1:0] kind;
      bit                   hit;
      if (mode == ModeInt || mode == ModeFrac) begin
        push_token(TkNumber, mant, frac_cnt, mant_sat, tok_start, pos - tok_start);
      end else if (mode == ModeWord) begin
        kind = TkIdent;
        for (int k = 0; k < NumKw; k++) begin
          hit = (word_len == kw_words[k].len());
          for (int i = 0; i < kw_words[k].len(); i++) begin
            if (hit && letters[i] != kw_words[k][i]) hit = 1'b0;
          end
          if (hit && kind == TkIdent) kind = TkKwBase + KindWidth'(k);
        end
        push_token(kind, 0, 0, 0, tok_start, pos - tok_start);
      end
      mode = ModeIdle;
    endfunction

    // one accepted input word: work out the tokens it gives
    function void note_word(bit eos, logic [7:0] c);
      bit taken;
      int slot;
      run_q.delete();
      taken = 1'b0;
      if (stuck) begin
        push_token(TkError, 0, 0, 0, tok_start, 1);
      end else if (eos) begin
        finish_pending();
        push_token(TkEof, 0, 0, 0, pos, 0);
      end else begin
        if (mode == ModeInt || mode == ModeFrac) begin
          if (digit_byte(c)) begin
            add_digit(int'(c) - 48);
            if (mode == ModeFrac && frac_cnt < 255) frac_cnt++;
            taken = 1'b1;
          end else if (c == 8'h2e && mode == ModeInt) begin
            mode  = ModeFrac;
            taken = 1'b1;
          end else begin
            finish_pending();
          end
        end else if (mode == ModeWord) begin
          if (digit_byte(c) || letter_byte(c)) begin
            if (word_len < KwBufLen) letters[word_len] = c;
            if (word_len <= KwBufLen) word_len++;
            taken = 1'b1;
          end else begin
            finish_pending();
          end
        end
        if (!taken) begin
          slot = mark_slot(c);
          if (digit_byte(c)) begin
            mode      = ModeInt;
            tok_start = pos;
            mant      = 0;
            mant_sat  = 1'b0;
            frac_cnt  = 0;
            add_digit(int'(c) - 48);
          end else if (letter_byte(c)) begin
            mode       = ModeWord;
            tok_start  = pos;
            letters[0] = c;
            word_len   = 1;
          end else if (slot >= 0) begin
            push_token(TkSemi + KindWidth'(slot), 0, 0, 0, pos, 1);
          end else if (!blank_byte(c)) begin
            stuck     = 1'b1;
            tok_start = pos;
            push_token(TkError, 0, 0, 0, tok_start, 1);
          end
        end
        if (pos < int'(PosMax)) pos++;
      end
      if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
    endfunction

    function string show(token_t t);
      return $sformatf("kind %0d mant %0d frac %0d ovf %0b start %0d len %0d last %0b",
                       t.kind, t.mantissa, t.frac, t.ovf, t.start, t.length, t.last);
    endfunction

    // one accepted output word against the oldest expected token
    function void check_token(token_t got);
      token_t want;
      bit     bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token at %0t: %s", $time, show(got));
      end else begin
        want = expected_q.pop_front();
        bad  = (got.kind !== want.kind) || (got.mantissa !== want.mantissa) ||
               (got.frac !== want.frac) || (got.ovf !== want.ovf) ||
               (got.start !== want.start) || (got.length !== want.length) ||
               (got.last !== want.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("token mismatch at %0t: expected %s, got %s", $time, show(want),
                     show(got));
          end
        end
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        in_kind   = 1'b0;
  logic [7:0]  in_char   = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_kind;
  logic [31:0] out_mant;
  logic [7:0]  out_frac;
  logic        out_ovf;
  logic [15:0] out_start;
  logic [15:0] out_len;
  logic        out_last;

  token_scoreboard sb;

  bit idle_on;     // random gaps on both sides
  bit hold_req;    // ask the receiver for one long hold-off
  bit hold_done;
  int stall_left;
  int words_sent;

  script_token_scanner uut (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_ready_o              (in_ready),
    .in_kind_i               (in_kind),
    .in_character_i          (in_char),
    .out_valid_o             (out_valid),
    .out_ready_i             (out_ready),
    .out_token_kind_o        (out_kind),
    .out_mantissa_o          (out_mant),
    .out_fraction_digits_o   (out_frac),
    .out_mantissa_overflow_o (out_ovf),
    .out_start_offset_o      (out_start),
    .out_token_length_o      (out_len),
    .out_last_of_run_o       (out_last)
  );

  always #1 clk = ~clk;

  // hard stop in case the handshake hangs
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int v;
    v = $urandom_range(0, 51);
    return (v < 26) ? 8'h61 + 8'(v) : 8'h41 + 8'(v - 26);
  endfunction

  // offer one word, hold it until taken, then let the predictor see it
  task automatic send_word(bit eos, logic [7:0] c);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= eos;
    in_char  <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_word(eos, c);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  // space or one of the control whitespace bytes 9..13
  task automatic send_blank();
    int v;
    v = $urandom_range(8, 13);
    send_word(1'b0, (v == 8) ? 8'h20 : 8'(v));
  endtask

  // one well-formed token with random content, plus a separator where needed
  task automatic random_token(int n);
    int         pick;
    int         len;
    int         sep;
    bit         dotted;
    bit         is_number;
    bit         upper;
    string      word;
    logic [7:0] c;
    pick      = $urandom_range(0, 99);
    dotted    = 1'b0;
    is_number = 1'b0;
    if (n < NumKw || pick < 20) begin
      // keyword, sometimes capitalized so that it turns into a plain identifier
      word  = sb.kw_words[(n < NumKw) ? n : $urandom_range(0, NumKw - 1)];
      upper = (n >= NumKw) && ($urandom_range(0, 4) == 0);
      for (int i = 0; i < word.len(); i++) begin
        c = word[i];
        if (i == 0 && upper) c = c - 8'h20;
        send_word(1'b0, c);
      end
    end else if (pick < 45) begin
      // number, now and then long enough to saturate the mantissa
      is_number = 1'b1;
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
      repeat (len) send_word(1'b0, rand_digit());
      if ($urandom_range(0, 1)) begin
        dotted = 1'b1;
        send_word(1'b0, 8'h2e);
        repeat ($urandom_range(0, 5)) send_word(1'b0, rand_digit());
      end
    end else if (pick < 60) begin
      // identifier, up to twelve characters, past the keyword buffer
      send_word(1'b0, rand_letter());
      repeat ($urandom_range(0, 11)) begin
        send_word(1'b0, ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
      end
    end else if (pick < 82) begin
      send_word(1'b0, sb.mark_chars[$urandom_range(0, 11)]);
    end else if (pick < 88) begin
      send_word(1'b1, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) send_blank();
    end
    // words and dotted numbers always get a separator so no stray point can follow;
    // a plain number may run straight into the next token
    if (pick < 60 || n < NumKw) begin
      sep = $urandom_range(0, (!is_number || dotted) ? 1 : 2);
      if (sep == 0) send_blank();
      else if (sep == 1) send_word(1'b0, sb.mark_chars[$urandom_range(0, 11)]);
    end
  endtask

  // output side: check each taken token, ready with random stalls
  initial begin : receiver
    token_t got;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.kind     = out_kind;
        got.mantissa = out_mant;
        got.frac     = out_frac;
        got.ovf      = out_ovf;
        got.start    = out_start;
        got.length   = out_len;
        got.last     = out_last;
        sb.check_token(got);
      end
      if (hold_req && !hold_done) begin
        // long hold-off so the token queue fills and the input stalls
        stall_left = 300;
        hold_done  = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int n;
    int base;
    int guard;
    sb      = new();
    idle_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every mark back to back
    send_text(";(){}+-*/<=,");
    // point with no digits after it
    send_text("3. ");
    // letter right after a number, then end of source with the word pending
    send_text("9z");
    send_word(1'b1, 8'h00);
    // end of source again
    send_word(1'b1, 8'ha5);
    // whitespace range ends
    send_word(1'b0, 8'h09);
    send_word(1'b0, 8'h0d);

    // random token stream; the long hold-off happens early in it
    hold_req = 1'b1;
    base     = words_sent;
    n        = 0;
    while (words_sent - base < 500) begin
      if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      random_token(n);
      n++;
    end

    // last part without gaps
    idle_on = 1'b0;
    // fraction digit count saturates
    send_text("0.");
    repeat (260) send_word(1'b0, 8'h37);
    send_blank();
    // long identifier, long number, then end of source with a word pending
    send_text("abcdefghijkl 12345678;x1");
    send_word(1'b1, 8'h5a);
    // second point in a number: the point is a bad byte and the error sticks
    send_text("1.2.");
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hff);
    send_word(1'b1, 8'h80);
    repeat (37) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    // drain, then give stray tokens time to show up
    guard = 0;
    while (sb.pending() > 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
